// File: hw/rtl/jsh_pkg.sv
// jsh_pkg: shared types and constants for the JTAG shift engine.
// Used by jsh_cfg, jsh_core and jtag_shift_engine; depends on nothing.
`default_nettype none

package jsh_pkg;

  localparam int WORD_BITS  = 32;
  localparam int DELAY_BITS = 16;
  localparam int CNT_BITS   = 6;
  localparam int IDX_BITS   = $clog2(WORD_BITS);

  localparam logic [DELAY_BITS-1:0] HALF_PERIOD_RESET = DELAY_BITS'(50);

  // register index, taken from paddr[2]
  localparam logic REG_HALF_PERIOD = 1'b0;
  localparam logic REG_BROADCAST   = 1'b1;

  // item kind carried in s_tuser
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  typedef struct packed {
    logic [DELAY_BITS-1:0] half_period_ticks;
    logic                  broadcast_mode;
  } cfg_t;

  typedef struct packed {
    logic                 func;
    logic [CNT_BITS-1:0]  bit_count;
    logic [WORD_BITS-1:0] tms_bits;
    logic [WORD_BITS-1:0] tdi_bits;
    logic                 tdo_pin;
  } item_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] tdo_bits;
    logic                 done_res;
    logic                 busy_res;
    logic                 side_pin;
    logic                 tdi_pin;
    logic                 tms_pin;
    logic                 tck_pin;
  } res_t;

endpackage

`default_nettype wire

// File: hw/rtl/jsh_cfg.sv
// jsh_cfg: APB-style register file holding the TCK half period and broadcast mode.
// Depends on jsh_pkg.
`default_nettype none

module jsh_cfg
  import jsh_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  output cfg_t             cfg
);

  logic wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.half_period_ticks <= HALF_PERIOD_RESET;
      cfg.broadcast_mode    <= 1'b0;
    end else if (wr) begin
      case (paddr[2])
        REG_HALF_PERIOD: cfg.half_period_ticks <= pwdata[DELAY_BITS-1:0];
        REG_BROADCAST:   cfg.broadcast_mode    <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_HALF_PERIOD: prdata = 32'(cfg.half_period_ticks);
      REG_BROADCAST:   prdata = 32'(cfg.broadcast_mode);
      default:         prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// File: hw/rtl/jsh_core.sv
// jsh_core: shift state and the single-pass update for one load or tick item.
// Depends on jsh_pkg; driven from the input register of jtag_shift_engine.
`default_nettype none

module jsh_core
  import jsh_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  step,
  input  item_t      item,
  input  cfg_t       cfg,
  output res_t       res
);

  logic [WORD_BITS-1:0]  tms_saved, tms_saved_next;
  logic [WORD_BITS-1:0]  tdi_saved, tdi_saved_next;
  logic [WORD_BITS-1:0]  tdo_capture, tdo_capture_next;
  logic [CNT_BITS-1:0]   count_loaded, count_loaded_next;
  logic [CNT_BITS-1:0]   bit_index, bit_index_next;
  logic [DELAY_BITS-1:0] phase_ticks, phase_ticks_next;
  logic                  phase_high, phase_high_next;
  logic                  second_pass, second_pass_next;
  logic                  running, running_next;
  logic [IDX_BITS-1:0]   b;
  logic [CNT_BITS-1:0]   cnt_sat;
  logic [CNT_BITS-1:0]   bit_inc;
  logic                  done;

  assign b       = bit_index[IDX_BITS-1:0];
  assign cnt_sat = (item.bit_count > CNT_BITS'(WORD_BITS)) ? CNT_BITS'(WORD_BITS)
                                                           : item.bit_count;
  assign bit_inc = bit_index + CNT_BITS'(1);

  always_comb begin
    tms_saved_next    = tms_saved;
    tdi_saved_next    = tdi_saved;
    tdo_capture_next  = tdo_capture;
    count_loaded_next = count_loaded;
    bit_index_next    = bit_index;
    phase_ticks_next  = phase_ticks;
    phase_high_next   = phase_high;
    second_pass_next  = second_pass;
    running_next      = running;
    done              = 1'b0;

    if (item.func == FUNC_LOAD) begin
      // a load while busy is dropped
      if (!running) begin
        tms_saved_next    = item.tms_bits;
        tdi_saved_next    = item.tdi_bits;
        tdo_capture_next  = '0;
        count_loaded_next = cnt_sat;
        bit_index_next    = '0;
        phase_ticks_next  = '0;
        phase_high_next   = 1'b0;
        second_pass_next  = 1'b0;
        if (cnt_sat == '0) begin
          done = 1'b1;
        end else begin
          running_next = 1'b1;
        end
      end
    end else if (running) begin
      if (phase_ticks >= cfg.half_period_ticks) begin
        phase_ticks_next = '0;
        if (!phase_high) begin
          // sample TDO at the end of the low phase, first pass only
          if (!second_pass && item.tdo_pin) begin
            tdo_capture_next[b] = 1'b1;
          end
          phase_high_next = 1'b1;
        end else begin
          phase_high_next = 1'b0;
          bit_index_next  = bit_inc;
          if (bit_inc >= count_loaded) begin
            bit_index_next = '0;
            if (cfg.broadcast_mode && !second_pass) begin
              second_pass_next = 1'b1;
            end else begin
              second_pass_next = 1'b0;
              running_next     = 1'b0;
              done             = 1'b1;
            end
          end
        end
      end else begin
        phase_ticks_next = phase_ticks + DELAY_BITS'(1);
      end
    end
  end

  always_comb begin
    res.tck_pin  = running ? phase_high     : 1'b0;
    res.tms_pin  = running ? tms_saved[b]   : 1'b1;
    res.tdi_pin  = running ? tdi_saved[b]   : 1'b0;
    res.side_pin = running ? second_pass    : 1'b0;
    res.busy_res = running_next;
    res.done_res = done;
    res.tdo_bits = tdo_capture_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tms_saved    <= '0;
      tdi_saved    <= '0;
      tdo_capture  <= '0;
      count_loaded <= '0;
      bit_index    <= '0;
      phase_ticks  <= '0;
      phase_high   <= 1'b0;
      second_pass  <= 1'b0;
      running      <= 1'b0;
    end else if (step) begin
      tms_saved    <= tms_saved_next;
      tdi_saved    <= tdi_saved_next;
      tdo_capture  <= tdo_capture_next;
      count_loaded <= count_loaded_next;
      bit_index    <= bit_index_next;
      phase_ticks  <= phase_ticks_next;
      phase_high   <= phase_high_next;
      second_pass  <= second_pass_next;
      running      <= running_next;
    end
  end

  a_index_in_range: assert property (@(posedge clk) disable iff (rst)
    running |-> (bit_index < count_loaded))
    else $error("bit index beyond loaded count");

  a_second_pass_running: assert property (@(posedge clk) disable iff (rst)
    second_pass |-> running)
    else $error("second pass flagged while idle");

  a_idle_cleared: assert property (@(posedge clk) disable iff (rst)
    !running |-> (bit_index == '0 && phase_ticks == '0 && !phase_high))
    else $error("shift counters not cleared while idle");

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    (step && res.done_res) |=> !running)
    else $error("shift still running after done");

endmodule

`default_nettype wire

// File: hw/rtl/jtag_shift_engine.sv
// jtag_shift_engine: JTAG master shifting up to 32 TMS/TDI bits per load.
// Usage:
//   Slave stream (s_tvalid/s_tready/s_tdata/s_tuser) carries items; s_tuser
//   is 0 for a load (bit count, TMS word, TDI word) and 1 for a tick that
//   carries the sampled TDO level. Every item yields one result on the master
//   stream (m_tvalid/m_tready/m_tdata): the pin levels driven during that
//   item, busy and done flags and the TDO capture word.
//   Each bit takes 2*(half_period_ticks+1) ticks; broadcast mode doubles it.
// Dataflow and throughput:
//   A transfer is taken into the input register, processed in one pass by
//   the shift core and held in the result register, from which its result
//   is offered on the master stream. One item is accepted per clock cycle
//   while results are taken.
// Stall: when m_tready is low the result register holds and the input
//   register keeps the next item; s_tready drops only when both are full.
// Reset (rst, synchronous): state cleared, pins idle (TMS high), half period
//   50, broadcast off. Registers over APB: 0x0 half period, 0x4 broadcast.
`default_nettype none

module jtag_shift_engine
  import jsh_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [71:0] s_tdata,   // bit_count[5:0], tms_bits[37:6], tdi_bits[69:38],
                                      // tdo_pin[70], zero[71]
  input  wire logic        s_tuser,   // func
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [39:0] m_tdata,   // tck_pin[0], tms_pin[1], tdi_pin[2], side_pin[3],
                                      // busy_res[4], done_res[5], tdo_bits[37:6], zero[39:38]
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  cfg_t  cfg;
  item_t item;
  res_t  res;
  logic  item_valid;
  logic  adv;

  assign adv      = item_valid && (!m_tvalid || m_tready);
  assign s_tready = !item_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      item_valid <= 1'b1;
    end else if (adv) begin
      item_valid <= 1'b0;
    end
  end

  // hold the item until the core consumes it
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item.func      <= s_tuser;
      item.bit_count <= s_tdata[5:0];
      item.tms_bits  <= s_tdata[37:6];
      item.tdi_bits  <= s_tdata[69:38];
      item.tdo_pin   <= s_tdata[70];
    end
  end

  jsh_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  jsh_core u_core (
    .clk  (clk),
    .rst  (rst),
    .step (adv),
    .item (item),
    .cfg  (cfg),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata <= {2'b00, res};
    end
  end

endmodule

`default_nettype wire

// File: bench/jtag_shift_engine_tb.sv
`timescale 1ns / 1ps
// jtag_shift_engine_tb: self-checking bench for the JTAG shift engine. An item-level
// predictor in a small scoreboard class checks every result on the master stream.
// Depends on jsh_pkg and jtag_shift_engine only.

module jtag_shift_engine_tb;
  import jsh_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 400;
  localparam logic [2:0] ADDR_HALF_PERIOD = {REG_HALF_PERIOD, 2'b00};
  localparam logic [2:0] ADDR_BROADCAST   = {REG_BROADCAST, 2'b00};

  // Pin-level predictor and store of expected results, one per transfer.
  class shift_checker;
    logic [DELAY_BITS-1:0] half_period;
    logic                  broadcast;
    logic [WORD_BITS-1:0]  tms_word;
    logic [WORD_BITS-1:0]  tdi_word;
    logic [WORD_BITS-1:0]  tdo_word;
    logic [CNT_BITS-1:0]   bits_loaded;
    logic [CNT_BITS-1:0]   bit_pos;
    logic [DELAY_BITS-1:0] phase_count;
    logic                  tck_high;
    logic                  second_pass;
    logic                  shifting;
    res_t                  expected_pins[$];
    int                    errors;

    function new();
      half_period = HALF_PERIOD_RESET;
      broadcast   = 1'b0;
      tms_word    = '0;
      tdi_word    = '0;
      tdo_word    = '0;
      bits_loaded = '0;
      bit_pos     = '0;
      phase_count = '0;
      tck_high    = 1'b0;
      second_pass = 1'b0;
      shifting    = 1'b0;
      errors      = 0;
    endfunction

    function void report(string msg);
      $display("%0t ns mismatch: %s", $time, msg);
      errors++;
    endfunction

    // Returns 1 when the item does work: a load taken while idle or a tick while shifting.
    function bit note_item(item_t it);
      res_t                r;
      logic [CNT_BITS-1:0] n;
      bit                  took;
      r = '0;
      r.tms_pin = 1'b1;
      took = 1'b0;
      if (shifting) begin
        r.tck_pin  = tck_high;
        r.tms_pin  = tms_word[bit_pos[IDX_BITS-1:0]];
        r.tdi_pin  = tdi_word[bit_pos[IDX_BITS-1:0]];
        r.side_pin = second_pass;
      end
      if (it.func == FUNC_LOAD) begin
        if (!shifting) begin
          took = 1'b1;
          n = (it.bit_count > WORD_BITS) ? CNT_BITS'(WORD_BITS) : it.bit_count;
          tms_word    = it.tms_bits;
          tdi_word    = it.tdi_bits;
          tdo_word    = '0;
          bits_loaded = n;
          bit_pos     = '0;
          phase_count = '0;
          tck_high    = 1'b0;
          second_pass = 1'b0;
          if (n == 0) r.done_res = 1'b1;
          else shifting = 1'b1;
        end
      end else if (shifting) begin
        took = 1'b1;
        if (phase_count >= half_period) begin
          phase_count = '0;
          if (!tck_high) begin
            // sample TDO at the end of the low phase, first pass only
            if (!second_pass && it.tdo_pin) tdo_word[bit_pos[IDX_BITS-1:0]] = 1'b1;
            tck_high = 1'b1;
          end else begin
            tck_high = 1'b0;
            bit_pos  = bit_pos + 1'b1;
            if (bit_pos >= bits_loaded) begin
              bit_pos = '0;
              if (broadcast && !second_pass) begin
                second_pass = 1'b1;
              end else begin
                second_pass = 1'b0;
                shifting    = 1'b0;
                r.done_res  = 1'b1;
              end
            end
          end
        end else begin
          phase_count = phase_count + 1'b1;
        end
      end
      r.busy_res = shifting;
      r.tdo_bits = tdo_word;
      expected_pins.push_back(r);
      return took;
    endfunction

    function void compare(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) report($sformatf("%s got %h want %h", name, got, want));
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (expected_pins.size() == 0) begin
        report($sformatf("result %h with nothing pending", got));
        return;
      end
      want = expected_pins.pop_front();
      compare("tck_pin", got.tck_pin, want.tck_pin);
      compare("tms_pin", got.tms_pin, want.tms_pin);
      compare("tdi_pin", got.tdi_pin, want.tdi_pin);
      compare("side_pin", got.side_pin, want.side_pin);
      compare("busy_res", got.busy_res, want.busy_res);
      compare("done_res", got.done_res, want.done_res);
      compare("tdo_bits", got.tdo_bits, want.tdo_bits);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [71:0] s_tdata;   // bit_count[5:0], tms_bits[37:6], tdi_bits[69:38], tdo_pin[70], zero[71]
  logic        s_tuser;   // func
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;   // tck_pin[0], tms_pin[1], tdi_pin[2], side_pin[3], busy_res[4],
                          // done_res[5], tdo_bits[37:6], zero[39:38]
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  shift_checker sb;
  int           idle_pct;
  int           worked;
  int           cycles;
  bit           mid_changes;

  jtag_shift_engine uut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= idle_pct);
  end

  always @(posedge clk) begin
    cycles++;
    if (!rst && m_tvalid && m_tready) sb.check_result(res_t'(m_tdata[37:0]));
    if (cycles > CYCLE_LIMIT) begin
      $display("** jtag_shift_engine: FAILED **");
      $finish;
    end
  end

  function automatic item_t tick_item(logic tdo);
    item_t it;
    it.func      = FUNC_TICK;
    it.bit_count = CNT_BITS'($urandom);
    it.tms_bits  = $urandom;
    it.tdi_bits  = $urandom;
    it.tdo_pin   = tdo;
    return it;
  endfunction

  function automatic item_t load_item(logic [CNT_BITS-1:0] n, logic [31:0] tms,
                                      logic [31:0] tdi);
    item_t it;
    it.func      = FUNC_LOAD;
    it.bit_count = n;
    it.tms_bits  = tms;
    it.tdi_bits  = tdi;
    it.tdo_pin   = 1'($urandom_range(1));
    return it;
  endfunction

  // Offer one item and hold it until the transfer; tvalid stays high for the next one.
  task automatic send_item(input item_t it);
    if ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 40);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= it.func;
    s_tdata  <= {1'b0, it.tdo_pin, it.tdi_bits, it.tms_bits, it.bit_count};
    do @(posedge clk); while (!s_tready);
    if (sb.note_item(it)) worked++;
  endtask

  // Back-to-back capable APB transfer; psel is left high for the caller to drop.
  task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wr ? data : 32'h0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (!wr && prdata !== data)
      sb.report($sformatf("read of %h gave %h want %h", addr, prdata, data));
  endtask

  // Drain the stream, then rewrite both registers and read them back.
  task automatic change_config(input logic [DELAY_BITS-1:0] hp, input logic bc);
    s_tvalid <= 1'b0;
    while (sb.expected_pins.size() != 0) @(negedge clk);
    @(posedge clk);
    apb_access(1'b1, ADDR_HALF_PERIOD, 32'(hp));
    sb.half_period = hp;
    apb_access(1'b1, ADDR_BROADCAST, 32'(bc));
    sb.broadcast = bc;
    apb_access(1'b0, ADDR_HALF_PERIOD, 32'(hp));
    apb_access(1'b0, ADDR_BROADCAST, 32'(bc));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Tick until the shift ends, with stray loads and the odd register change mixed in.
  task automatic finish_shift();
    while (sb.shifting) begin
      if (mid_changes && $urandom_range(149) == 0)
        change_config(DELAY_BITS'($urandom_range(2)), 1'($urandom_range(1)));
      else if ($urandom_range(99) < 3)
        send_item(load_item(CNT_BITS'($urandom), $urandom, $urandom));
      else
        send_item(tick_item(1'($urandom_range(1))));
    end
    repeat ($urandom_range(2)) send_item(tick_item(1'($urandom_range(1))));
  endtask

  task automatic run_shift();
    int                  r;
    logic [CNT_BITS-1:0] n;
    r = $urandom_range(99);
    if (r < 4) n = '0;
    else if (r < 7) n = CNT_BITS'($urandom_range(63, 32));
    else if (r < 15) n = CNT_BITS'($urandom_range(31, 5));
    else n = CNT_BITS'($urandom_range(4, 1));
    send_item(load_item(n, $urandom, $urandom));
    finish_shift();
  endtask

  initial begin
    sb          = new();
    idle_pct    = 7;
    worked      = 0;
    cycles      = 0;
    mid_changes = 1'b0;
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= FUNC_TICK;
    m_tready <= 1'b0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    apb_access(1'b0, ADDR_HALF_PERIOD, 32'(HALF_PERIOD_RESET));
    apb_access(1'b0, ADDR_BROADCAST, 32'h0);
    psel    <= 1'b0;
    penable <= 1'b0;

    // idle tick, then a zero-length load that finishes at once
    send_item(tick_item(1'b1));
    send_item(load_item('0, '1, '1));
    change_config('0, 1'b0);
    send_item(load_item(CNT_BITS'(2), '1, '0));
    send_item(load_item(CNT_BITS'(5), '0, '1));   // busy: dropped
    repeat (4) send_item(tick_item(1'b1));
    send_item(load_item(CNT_BITS'(1), '0, '1));
    send_item(tick_item(1'b0));
    send_item(tick_item(1'b1));
    send_item(tick_item(1'b0));
    // broadcast: TDO high only on the second pass must not be captured
    change_config('0, 1'b1);
    send_item(load_item(CNT_BITS'(1), 32'hAAAA_AAAA, 32'h5555_5555));
    send_item(tick_item(1'b0));
    send_item(tick_item(1'b0));
    send_item(tick_item(1'b1));
    send_item(tick_item(1'b1));
    // slowest timing, then shrink the half period while the counter is well past it
    change_config('1, 1'b1);
    send_item(load_item(CNT_BITS'(3), $urandom, $urandom));
    repeat (12) send_item(tick_item(1'($urandom_range(1))));
    change_config('0, 1'b1);
    finish_shift();

    change_config('0, 1'b0);
    send_item(load_item(CNT_BITS'(63), $urandom, $urandom));   // saturates to a full word
    finish_shift();

    worked = 0;
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: change_config(DELAY_BITS'(0), 1'b0);
        1: change_config(DELAY_BITS'(1), 1'b1);
        2: change_config(DELAY_BITS'(0), 1'b1);
        3: change_config(DELAY_BITS'(2), 1'b0);
        default: change_config(DELAY_BITS'($urandom_range(1)), 1'($urandom_range(1)));
      endcase
      idle_pct    = (p == 2) ? 0 : 7;
      mid_changes = (p >= 4);
      while (worked < (p + 1) * RANDOM_ITEMS / 6) run_shift();
    end
    mid_changes = 1'b0;
    idle_pct    = 7;

    s_tvalid <= 1'b0;
    while (sb.expected_pins.size() != 0) @(negedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0)
      $display("** jtag_shift_engine: PASSED **");
    else
      $display("** jtag_shift_engine: FAILED **");
    $finish;
  end

endmodule
